FILE: rtl/core/bvf_pkg.sv
// Shared constants and types for the brush vertex falloff weight block.
// Holds register indexes, falloff curve codes and fixed thresholds.
// Depends on nothing.
package bvf_pkg;

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_SMOOTH = 2'd1,
        MODE_SHARP  = 2'd2,
        MODE_NONE   = 2'd3
    } falloff_mode_t;

    typedef enum logic [2:0] {
        REG_ROW_X  = 3'd0,
        REG_ROW_Y  = 3'd1,
        REG_ROW_Z  = 3'd2,
        REG_CENTER = 3'd3,
        REG_RADIUS = 3'd4,
        REG_MODE   = 3'd5,
        REG_RSVD6  = 3'd6,
        REG_RSVD7  = 3'd7
    } reg_index_t;

    localparam int unsigned MAX_VERTICES = 65536;
    localparam logic [15:0] WEIGHT_MIN   = 16'd65;
    localparam logic [15:0] WEIGHT_MAX   = 16'hFFFF;
    localparam int unsigned T_BITS       = 16;

    localparam logic [63:0] ROW_X_RESET  = 64'd4096;
    localparam logic [63:0] ROW_Y_RESET  = 64'd4096 << 16;
    localparam logic [63:0] ROW_Z_RESET  = 64'd4096 << 32;
    localparam logic [15:0] RADIUS_RESET = 16'd256;

endpackage

FILE: rtl/core/brush_vertex_falloff_weight.sv
// Top level of the brush vertex falloff weight block.
// Holds the APB register file and the full compute pipeline.
// Depends on bvf_pkg.
//
// Usage: vertices enter on the s_axis channel, one transaction per vertex
// (index and local x, y, z). The block maps each vertex to world space,
// tests it against the brush sphere and, for a vertex inside with a weight
// above the 0.001 threshold, sends index and weight on the m_axis channel.
// Other vertices produce nothing.
// Throughput: one vertex per cycle while the output is not stalled.
// The pipeline depth is set mainly by the 16-stage bit-serial
// distance-over-radius extraction, one quotient bit per stage.
// The pipeline advances whenever the output register is empty or taken, so
// a stalled receiver holds every stage and the input; nothing is dropped.
// Reset clears all valid bits and loads the register defaults (identity
// matrix, center at origin, radius 1.0, linear falloff). Write registers
// only while no vertex is in flight.
module brush_vertex_falloff_weight (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vertex_index[15:0], local_x[31:16], local_y[47:32], local_z[63:48]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // hit_index[15:0], weight[31:16]
    output logic [31:0] m_axis_tdata
);

    localparam int NS = bvf_pkg::T_BITS;

    logic [63:0] row_x_reg, row_y_reg, row_z_reg;
    logic [47:0] center_reg;
    logic [15:0] radius_reg;
    logic [31:0] rsq_reg;
    logic [1:0]  mode_reg;
    logic        wr;
    bvf_pkg::reg_index_t widx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = bvf_pkg::reg_index_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg  <= bvf_pkg::ROW_X_RESET;
            row_y_reg  <= bvf_pkg::ROW_Y_RESET;
            row_z_reg  <= bvf_pkg::ROW_Z_RESET;
            center_reg <= '0;
            radius_reg <= bvf_pkg::RADIUS_RESET;
            rsq_reg    <= 32'(bvf_pkg::RADIUS_RESET) * 32'(bvf_pkg::RADIUS_RESET);
            mode_reg   <= bvf_pkg::MODE_LINEAR;
        end
        else if (wr)
        begin
            case (widx)
                bvf_pkg::REG_ROW_X:  row_x_reg  <= pwdata;
                bvf_pkg::REG_ROW_Y:  row_y_reg  <= pwdata;
                bvf_pkg::REG_ROW_Z:  row_z_reg  <= pwdata;
                bvf_pkg::REG_CENTER: center_reg <= pwdata[47:0];
                bvf_pkg::REG_RADIUS:
                begin
                    radius_reg <= pwdata[15:0];
                    rsq_reg    <= 32'(pwdata[15:0]) * 32'(pwdata[15:0]);
                end
                bvf_pkg::REG_MODE:   mode_reg   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            bvf_pkg::REG_ROW_X:  prdata = row_x_reg;
            bvf_pkg::REG_ROW_Y:  prdata = row_y_reg;
            bvf_pkg::REG_ROW_Z:  prdata = row_z_reg;
            bvf_pkg::REG_CENTER: prdata = {16'd0, center_reg};
            bvf_pkg::REG_RADIUS: prdata = {48'd0, radius_reg};
            bvf_pkg::REG_MODE:   prdata = {62'd0, mode_reg};
            default:             prdata = '0;
        endcase
    end

    logic adv;
    logic out_valid_reg;
    logic [31:0] out_data_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // stage 1: nine coefficient products
    logic        v1_reg;
    logic [15:0] i1_reg;
    logic signed [31:0] p1_reg [0:2][0:2];
    logic signed [15:0] vx, vy, vz;
    logic [63:0] rows [0:2];

    assign vx = signed'(s_axis_tdata[31:16]);
    assign vy = signed'(s_axis_tdata[47:32]);
    assign vz = signed'(s_axis_tdata[63:48]);
    assign rows[0] = row_x_reg;
    assign rows[1] = row_y_reg;
    assign rows[2] = row_z_reg;

    // stage 2: axis differences, magnitudes
    logic        v2_reg;
    logic [15:0] i2_reg;
    logic [27:0] m2_reg [0:2];
    logic signed [35:0] diff [0:2];
    logic [35:0] dmag [0:2];
    logic [2:0]  near;
    logic [27:0] r20;

    assign r20 = {radius_reg, 12'd0};

    // stage 3: squares
    logic        v3_reg;
    logic [15:0] i3_reg;
    logic [55:0] q3_reg [0:2];

    // stage 4: squared distance
    logic        v4_reg;
    logic [15:0] i4_reg;
    logic [65:0] lim4_reg;
    logic [57:0] d2;

    assign d2 = 58'(q3_reg[0]) + 58'(q3_reg[1]) + 58'(q3_reg[2]);

    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_axis
            always_comb
            begin
                diff[a] = 36'(p1_reg[a][0]) + 36'(p1_reg[a][1]) + 36'(p1_reg[a][2])
                        + (36'(signed'(rows[a][63:48])) <<< 12)
                        - (36'(signed'(center_reg[16*a +: 16])) <<< 12);
                dmag[a] = diff[a][35] ? 36'(-diff[a]) : 36'(diff[a]);
                near[a] = dmag[a] < 36'(r20);
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i1_reg <= s_axis_tdata[15:0];
            for (int r = 0; r < 3; r++)
            begin
                p1_reg[r][0] <= 32'(signed'(rows[r][15:0]))  * 32'(vx);
                p1_reg[r][1] <= 32'(signed'(rows[r][31:16])) * 32'(vy);
                p1_reg[r][2] <= 32'(signed'(rows[r][47:32])) * 32'(vz);
            end
            i2_reg <= i1_reg;
            for (int r = 0; r < 3; r++)
            begin
                m2_reg[r] <= dmag[r][27:0];
                q3_reg[r] <= 56'(m2_reg[r]) * 56'(m2_reg[r]);
            end
            i3_reg   <= i2_reg;
            i4_reg   <= i3_reg;
            lim4_reg <= {d2, 8'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid && (radius_reg != 16'd0)
                   && (32'(s_axis_tdata[15:0]) < 32'(bvf_pkg::MAX_VERTICES));
            v2_reg <= v1_reg && (&near);
            v3_reg <= v2_reg;
            v4_reg <= v3_reg && (d2 < (58'(rsq_reg) << 24));
        end
    end

    // bit-serial t: largest t with (t*r)^2 <= lim, one bit per stage
    logic        sv_reg [0:NS];
    logic [15:0] si_reg [0:NS];
    logic [15:0] st_reg [0:NS];
    logic [65:0] sp_reg [0:NS];
    logic [47:0] sa_reg [0:NS];
    logic [65:0] sl_reg [0:NS];

    assign sv_reg[0] = v4_reg;
    assign si_reg[0] = i4_reg;
    assign st_reg[0] = '0;
    assign sp_reg[0] = '0;
    assign sa_reg[0] = '0;
    assign sl_reg[0] = lim4_reg;

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_bit
            localparam int K = NS - 1 - s;
            logic [65:0] cand;
            logic        take;

            assign cand = sp_reg[s] + (66'(sa_reg[s]) << (K + 1))
                        + (66'(rsq_reg) << (2 * K));
            assign take = cand <= sl_reg[s];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    si_reg[s+1] <= si_reg[s];
                    sl_reg[s+1] <= sl_reg[s];
                    st_reg[s+1] <= take ? (st_reg[s] | (16'd1 << K)) : st_reg[s];
                    sp_reg[s+1] <= take ? cand : sp_reg[s];
                    sa_reg[s+1] <= take ? 48'(sa_reg[s] + (48'(rsq_reg) << K))
                                        : sa_reg[s];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg[s+1] <= 1'b0;
                else if (adv)
                    sv_reg[s+1] <= sv_reg[s];
            end
        end
    endgenerate

    // weight curve stages
    logic        v5_reg, v6_reg;
    logic [15:0] i5_reg, i6_reg, t5_reg, t6_reg;
    logic [31:0] t2_5_reg, t2_6_reg;
    logic [47:0] t3_6_reg;
    logic [49:0] h;
    logic [16:0] w;
    logic [15:0] wsat;

    always_comb
    begin
        h = 50'({t2_6_reg, 16'd0}) + 50'({t2_6_reg, 17'd0}) - 50'({t3_6_reg, 1'b0});
        case (bvf_pkg::falloff_mode_t'(mode_reg))
            bvf_pkg::MODE_LINEAR: w = 17'h10000 - 17'(t6_reg);
            bvf_pkg::MODE_SMOOTH: w = 17'((50'd1 << 48) - h >> 32);
            bvf_pkg::MODE_SHARP:  w = 17'((49'd1 << 48) - 49'(t3_6_reg) >> 32);
            default:              w = '0;
        endcase
        wsat = w[16] ? bvf_pkg::WEIGHT_MAX : w[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i5_reg   <= si_reg[NS];
            t5_reg   <= st_reg[NS];
            t2_5_reg <= 32'(st_reg[NS]) * 32'(st_reg[NS]);
            i6_reg   <= i5_reg;
            t6_reg   <= t5_reg;
            t2_6_reg <= t2_5_reg;
            t3_6_reg <= 48'(t2_5_reg) * 48'(t5_reg);
            out_data_reg <= {wsat, i6_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg        <= sv_reg[NS];
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg && (wsat > bvf_pkg::WEIGHT_MIN);
        end
    end

endmodule

FILE: rtl/core/bvf_checker.sv
// Port-level checks for the brush vertex falloff weight block.
// Bound to brush_vertex_falloff_weight; depends on bvf_pkg.
module bvf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transaction changed");

    a_weight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:16] > bvf_pkg::WEIGHT_MIN)
        else $error("weight at or below threshold sent");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output register");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

endmodule

bind brush_vertex_falloff_weight bvf_checker u_bvf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
